### hw/rtl/clcd_pkg.sv
// clcd_pkg: shared types, codes and reset values for the character LCD
// command stream. No dependencies; used by every module of the block.
package clcd_pkg;

    // Display geometry defaults
    localparam int ROWS_DEF = 2;
    localparam int COLS_DEF = 16;

    // Request codes on the input channel
    localparam logic [1:0] CMD_PUTC  = 2'd0;
    localparam logic [1:0] CMD_SETCUR = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_LIGHT = 2'd3;

    // Character codes with special handling
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PR_LO  = 8'h20;
    localparam logic [7:0] CH_PR_HI  = 8'h7E;

    // Configuration register indexes
    localparam logic [2:0] REG_PREFIX    = 3'd0;
    localparam logic [2:0] REG_POSITION  = 3'd1;
    localparam logic [2:0] REG_CLEAR     = 3'd2;
    localparam logic [2:0] REG_LIGHT_ON  = 3'd3;
    localparam logic [2:0] REG_LIGHT_OFF = 3'd4;

    // Configuration reset values
    localparam logic [7:0] PREFIX_RST    = 8'd254;
    localparam logic [7:0] POSITION_RST  = 8'd0;
    localparam logic [7:0] CLEAR_RST     = 8'd1;
    localparam logic [7:0] LIGHT_ON_RST  = 8'd0;
    localparam logic [7:0] LIGHT_OFF_RST = 8'd0;

    // Job kinds handed from front to back
    localparam logic [2:0] K_CHAR      = 3'd0; // byte
    localparam logic [2:0] K_CHAR_WRAP = 3'd1; // byte, then positioning
    localparam logic [2:0] K_PLACE     = 3'd2; // positioning
    localparam logic [2:0] K_ERASE     = 3'd3; // positioning, space, positioning
    localparam logic [2:0] K_CLEAR     = 3'd4; // prefix, clear code
    localparam logic [2:0] K_LIGHT     = 3'd5; // prefix, on/off code

    // Job queue depth
    localparam int QDEPTH = 2;
    localparam int Q_AW   = 1;
    localparam int Q_CW   = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;   // character, or backlight flag in bit 0
        logic [7:0] pcol;   // column + 1 for positioning
        logic [7:0] prow;   // row + 1 for positioning
    } t_job;

    typedef struct packed {
        logic [7:0] prefix;
        logic [7:0] position;
        logic [7:0] clear;
        logic [7:0] light_on;
        logic [7:0] light_off;
    } t_cfg;

endpackage

### hw/rtl/char_lcd_cursor_command_stream.sv
// Character LCD command stream: requests in, display bytes out, cursor tracked.
// A request's job passes through the job queue and the back end's output register.
// The back end sends one byte per cycle while the output is not stalled; a request
// yields 1 to 9 bytes, and requests with no bytes queue no job in the front.
// The front accepts a request every cycle while the two-entry job queue has room.
// Reset (synchronous, active low) homes the cursor, empties the queue, loads codes.
module char_lcd_cursor_command_stream #(
    parameter int ROWS = clcd_pkg::ROWS_DEF,
    parameter int COLS = clcd_pkg::COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_target_row,
    input  logic [7:0]  i_target_col,
    input  logic        i_light_enable,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);
    clcd_pkg::t_cfg r_cfg;
    clcd_pkg::t_job w_push_job, w_head_job;
    logic           w_accept, w_push, w_pop, w_full, w_nempty;

    // Configuration register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix    <= clcd_pkg::PREFIX_RST;
            r_cfg.position  <= clcd_pkg::POSITION_RST;
            r_cfg.clear     <= clcd_pkg::CLEAR_RST;
            r_cfg.light_on  <= clcd_pkg::LIGHT_ON_RST;
            r_cfg.light_off <= clcd_pkg::LIGHT_OFF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                clcd_pkg::REG_PREFIX:    r_cfg.prefix    <= i_cfg_data;
                clcd_pkg::REG_POSITION:  r_cfg.position  <= i_cfg_data;
                clcd_pkg::REG_CLEAR:     r_cfg.clear     <= i_cfg_data;
                clcd_pkg::REG_LIGHT_ON:  r_cfg.light_on  <= i_cfg_data;
                clcd_pkg::REG_LIGHT_OFF: r_cfg.light_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input beat taken whenever the queue has room
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    clcd_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_target_row   (i_target_row),
        .i_target_col   (i_target_col),
        .i_light_enable (i_light_enable),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    clcd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_nempty (w_nempty),
        .o_job    (w_head_job)
    );

    clcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_nempty    (w_nempty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

### hw/rtl/clcd_front.sv
// clcd_front: accepts requests, tracks the cursor and turns each request
// into at most one job for the queue. Depends on clcd_pkg.
module clcd_front #(
    parameter int ROWS = clcd_pkg::ROWS_DEF,
    parameter int COLS = clcd_pkg::COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_char_code,
    input  logic [7:0]        i_target_row,
    input  logic [7:0]        i_target_col,
    input  logic              i_light_enable,
    output logic              o_push,
    output clcd_pkg::t_job    o_job
);
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] w_row_inc;
    logic [COL_W:0]   w_col_inc;
    logic             w_emit;
    logic [2:0]       w_kind;

    // Next row modulo the row count, next column before the wrap check
    assign w_row_inc = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + 1'b1;
    assign w_col_inc = {1'b0, r_col} + 1'b1;

    // Classify the beat and update the cursor
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        w_emit = 1'b0;
        w_kind = clcd_pkg::K_PLACE;
        case (i_cmd)
            clcd_pkg::CMD_PUTC: begin
                if (i_char_code == clcd_pkg::CH_LF) begin
                    n_row  = w_row_inc;
                    n_col  = '0;
                    w_emit = 1'b1;
                end else if (i_char_code == clcd_pkg::CH_CR) begin
                    n_col  = '0;
                    w_emit = 1'b1;
                end else if (i_char_code == clcd_pkg::CH_BS) begin
                    if (r_col != '0) begin
                        n_col  = r_col - 1'b1;
                        w_emit = 1'b1;
                        w_kind = clcd_pkg::K_ERASE;
                    end
                end else if (i_char_code >= clcd_pkg::CH_PR_LO &&
                             i_char_code <= clcd_pkg::CH_PR_HI) begin
                    w_emit = 1'b1;
                    if (w_col_inc >= (COL_W+1)'(COLS)) begin
                        n_col  = '0;
                        n_row  = w_row_inc;
                        w_kind = clcd_pkg::K_CHAR_WRAP;
                    end else begin
                        n_col  = w_col_inc[COL_W-1:0];
                        w_kind = clcd_pkg::K_CHAR;
                    end
                end
            end
            clcd_pkg::CMD_SETCUR: begin
                if (i_target_row < 8'(ROWS) && i_target_col < 8'(COLS)) begin
                    n_row  = i_target_row[ROW_W-1:0];
                    n_col  = i_target_col[COL_W-1:0];
                    w_emit = 1'b1;
                end
            end
            clcd_pkg::CMD_CLEAR: begin
                n_row  = '0;
                n_col  = '0;
                w_emit = 1'b1;
                w_kind = clcd_pkg::K_CLEAR;
            end
            default: begin
                w_emit = 1'b1;
                w_kind = clcd_pkg::K_LIGHT;
            end
        endcase
    end

    // Job built from the updated cursor
    assign o_push     = i_accept & w_emit;
    assign o_job.kind = w_kind;
    assign o_job.data = (w_kind == clcd_pkg::K_LIGHT) ? {7'd0, i_light_enable}
                                                      : i_char_code;
    assign o_job.pcol = 8'(n_col) + 8'd1;
    assign o_job.prow = 8'(n_row) + 8'd1;

    // Cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

### hw/rtl/clcd_fifo.sv
// clcd_fifo: short job queue between front and back.
// Depends on clcd_pkg.
module clcd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  clcd_pkg::t_job    i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nempty,
    output clcd_pkg::t_job    o_job
);
    clcd_pkg::t_job r_mem [clcd_pkg::QDEPTH];
    logic [clcd_pkg::Q_AW-1:0] r_wptr, r_rptr;
    logic [clcd_pkg::Q_CW-1:0] r_cnt;

    assign o_full   = (r_cnt == clcd_pkg::Q_CW'(clcd_pkg::QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_job    = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == clcd_pkg::Q_AW'(clcd_pkg::QDEPTH - 1)) ? '0
                                                                           : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == clcd_pkg::Q_AW'(clcd_pkg::QDEPTH - 1)) ? '0
                                                                           : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/clcd_back.sv
// clcd_back: walks each queued job and sends its bytes one beat a cycle, while
// the output is not stalled, through an output register. Depends on clcd_pkg.
module clcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clcd_pkg::t_cfg    i_cfg,
    input  logic              i_nempty,
    input  clcd_pkg::t_job    i_job,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_last_byte
);
    logic [3:0] r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic       w_adv;
    logic       w_load;
    logic       w_use_place;
    logic [1:0] w_pidx;
    logic [7:0] w_other;
    logic [7:0] w_place;
    logic [7:0] w_byte;
    logic       w_last;
    logic [3:0] w_m1, w_m5;

    assign w_m1 = r_step - 4'd1;
    assign w_m5 = r_step - 4'd5;

    // Sequence of a job: which byte at this step and whether it ends the job
    always_comb begin
        w_use_place = 1'b0;
        w_pidx      = r_step[1:0];
        w_other     = i_job.data;
        w_last      = 1'b1;
        case (i_job.kind)
            clcd_pkg::K_CHAR: begin
                w_last = 1'b1;
            end
            clcd_pkg::K_CHAR_WRAP: begin
                w_use_place = (r_step != 4'd0);
                w_pidx      = w_m1[1:0];
                w_last      = (r_step == 4'd4);
            end
            clcd_pkg::K_PLACE: begin
                w_use_place = 1'b1;
                w_last      = (r_step == 4'd3);
            end
            clcd_pkg::K_ERASE: begin
                w_other     = clcd_pkg::CH_SPACE;
                w_use_place = (r_step != 4'd4);
                w_pidx      = (r_step < 4'd4) ? r_step[1:0] : w_m5[1:0];
                w_last      = (r_step == 4'd8);
            end
            clcd_pkg::K_CLEAR: begin
                w_other = (r_step == 4'd0) ? i_cfg.prefix : i_cfg.clear;
                w_last  = (r_step == 4'd1);
            end
            clcd_pkg::K_LIGHT: begin
                w_other = (r_step == 4'd0) ? i_cfg.prefix :
                          (i_job.data[0] ? i_cfg.light_on : i_cfg.light_off);
                w_last  = (r_step == 4'd1);
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    // Positioning bytes: prefix, position code, column + 1, row + 1
    always_comb begin
        case (w_pidx)
            2'd0:    w_place = i_cfg.prefix;
            2'd1:    w_place = i_cfg.position;
            2'd2:    w_place = i_job.pcol;
            default: w_place = i_job.prow;
        endcase
    end

    assign w_byte = w_use_place ? w_place : w_other;
    assign w_adv  = !r_valid || !i_out_stall;
    assign w_load = w_adv && i_nempty;
    assign o_pop  = w_load && w_last;

    // Step counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_nempty;
            if (w_load) begin
                r_step <= w_last ? 4'd0 : r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_last <= w_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for char_lcd_cursor_command_stream, a directed
// table then random display requests. Needs clcd_pkg and the block's RTL only.
module tb_top;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [7:0] trow;
        logic [7:0] tcol;
        logic       light;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_lcd_byte;

    // One directed row: request, plus up to four bytes typed in by hand
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  ch;
        logic [7:0]  trow;
        logic [7:0]  tcol;
        logic        light;
        logic        typed;
        logic [2:0]  n_exp;
        logic [31:0] exp_bytes;
    } t_dir_row;

    localparam int DIR_ROWS    = 24;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_BEATS = 73;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_cmd;
    logic [7:0] i_char_code;
    logic [7:0] i_target_row;
    logic [7:0] i_target_col;
    logic       i_light_enable;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_last_byte;

    // Cursor and code registers as the bench believes them to be
    int              trk_row;
    int              trk_col;
    clcd_pkg::t_cfg  code_regs;

    logic [7:0] seq_buf [$];
    t_lcd_byte  lcd_bytes_due [$];
    t_dir_row   dir_tab [0:DIR_ROWS-1];
    int         fail_count;
    int         send_idle_pct;
    int         stall_pct;

    char_lcd_cursor_command_stream u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_target_row   (i_target_row),
        .i_target_col   (i_target_col),
        .i_light_enable (i_light_enable),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    // Positioning sequence for the tracked cursor
    function automatic void add_place();
        seq_buf.push_back(code_regs.prefix);
        seq_buf.push_back(code_regs.position);
        seq_buf.push_back(8'(trk_col + 1));
        seq_buf.push_back(8'(trk_row + 1));
    endfunction

    // Bytes one request should produce; moves the tracked cursor
    function automatic void work_out_bytes(input t_req r);
        seq_buf.delete();
        case (r.cmd)
            clcd_pkg::CMD_PUTC: begin
                if (r.ch == clcd_pkg::CH_LF) begin
                    trk_row = (trk_row + 1) % clcd_pkg::ROWS_DEF;
                    trk_col = 0;
                    add_place();
                end else if (r.ch == clcd_pkg::CH_CR) begin
                    trk_col = 0;
                    add_place();
                end else if (r.ch == clcd_pkg::CH_BS) begin
                    // erase: step back, blank the cell, step back again
                    if (trk_col > 0) begin
                        trk_col = trk_col - 1;
                        add_place();
                        seq_buf.push_back(clcd_pkg::CH_SPACE);
                        add_place();
                    end
                end else if (r.ch >= clcd_pkg::CH_PR_LO && r.ch <= clcd_pkg::CH_PR_HI) begin
                    seq_buf.push_back(r.ch);
                    trk_col = trk_col + 1;
                    if (trk_col >= clcd_pkg::COLS_DEF) begin
                        trk_col = 0;
                        trk_row = (trk_row + 1) % clcd_pkg::ROWS_DEF;
                        add_place();
                    end
                end
            end
            clcd_pkg::CMD_SETCUR: begin
                if (r.trow < clcd_pkg::ROWS_DEF && r.tcol < clcd_pkg::COLS_DEF) begin
                    trk_row = r.trow;
                    trk_col = r.tcol;
                    add_place();
                end
            end
            clcd_pkg::CMD_CLEAR: begin
                seq_buf.push_back(code_regs.prefix);
                seq_buf.push_back(code_regs.clear);
                trk_row = 0;
                trk_col = 0;
            end
            default: begin
                seq_buf.push_back(code_regs.prefix);
                seq_buf.push_back(r.light ? code_regs.light_on : code_regs.light_off);
            end
        endcase
    endfunction

    function automatic void queue_expected();
        foreach (seq_buf[j])
            lcd_bytes_due.push_back('{seq_buf[j], j == seq_buf.size() - 1});
    endfunction

    // Random request: mostly well-formed text and cursor moves, some noise
    function automatic t_req pick_request();
        t_req r;
        int   pick;
        r.cmd   = clcd_pkg::CMD_PUTC;
        r.ch    = 8'($urandom);
        r.trow  = 8'($urandom);
        r.tcol  = 8'($urandom);
        r.light = 1'($urandom);
        pick    = $urandom_range(99);
        if (pick < 45) begin
            r.ch = 8'($urandom_range(clcd_pkg::CH_PR_HI, clcd_pkg::CH_PR_LO));
        end else if (pick < 49) begin
            r.ch = clcd_pkg::CH_LF;
        end else if (pick < 53) begin
            r.ch = clcd_pkg::CH_CR;
        end else if (pick < 62) begin
            r.ch = clcd_pkg::CH_BS;
        end else if (pick < 67) begin
            // any byte at all, mostly ignored
        end else if (pick < 80) begin
            r.cmd  = clcd_pkg::CMD_SETCUR;
            r.trow = 8'($urandom_range(clcd_pkg::ROWS_DEF - 1));
            r.tcol = 8'($urandom_range(clcd_pkg::COLS_DEF - 1));
        end else if (pick < 85) begin
            r.cmd = clcd_pkg::CMD_SETCUR;
            if ($urandom_range(1))
                r.trow = 8'($urandom_range(255, clcd_pkg::ROWS_DEF));
            else
                r.tcol = 8'($urandom_range(255, clcd_pkg::COLS_DEF));
        end else if (pick < 92) begin
            r.cmd = clcd_pkg::CMD_CLEAR;
        end else begin
            r.cmd = clcd_pkg::CMD_LIGHT;
        end
        return r;
    endfunction

    function automatic logic [7:0] code_for_phase(input int ph);
        if (ph == 0)
            return 8'h00;
        else if (ph == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= r.cmd;
        i_char_code    <= r.ch;
        i_target_row   <= r.trow;
        i_target_col   <= r.tcol;
        i_light_enable <= r.light;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic write_code(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            clcd_pkg::REG_PREFIX:   code_regs.prefix    = val;
            clcd_pkg::REG_POSITION: code_regs.position  = val;
            clcd_pkg::REG_CLEAR:    code_regs.clear     = val;
            clcd_pkg::REG_LIGHT_ON: code_regs.light_on  = val;
            default:                code_regs.light_off = val;
        endcase
    endtask

    // Hold off the sender until every byte has come, then let the front settle
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (lcd_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Receiver back-pressure
    always @(posedge i_clk)
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);

    // Compare each output beat with the oldest expected byte
    always @(posedge i_clk) begin : chk_out
        t_lcd_byte due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lcd_bytes_due.size() == 0) begin
                $error("out_byte: nothing expected, got %02h", o_out_byte);
                fail_count++;
            end else begin
                due = lcd_bytes_due.pop_front();
                if (o_out_byte !== due.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", due.out_byte, o_out_byte);
                    fail_count++;
                end
                if (o_last_byte !== due.last_byte) begin
                    $error("last_byte: expected %0b, got %0b", due.last_byte, o_last_byte);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_req r;
        int   k;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = clcd_pkg::REG_PREFIX;
        i_cfg_data     = 8'h00;
        i_in_valid     = 1'b0;
        i_cmd          = clcd_pkg::CMD_PUTC;
        i_char_code    = 8'h00;
        i_target_row   = 8'h00;
        i_target_col   = 8'h00;
        i_light_enable = 1'b0;
        fail_count     = 0;
        send_idle_pct  = 21;
        stall_pct      = 54;
        trk_row        = 0;
        trk_col        = 0;
        code_regs      = '{clcd_pkg::PREFIX_RST, clcd_pkg::POSITION_RST,
                           clcd_pkg::CLEAR_RST, clcd_pkg::LIGHT_ON_RST,
                           clcd_pkg::LIGHT_OFF_RST};

        // cmd, char, row, col, light | typed, count, bytes (reset codes)
        dir_tab[0]  = '{clcd_pkg::CMD_CLEAR,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd2,
                        {clcd_pkg::PREFIX_RST, clcd_pkg::CLEAR_RST, 16'h0}};
        dir_tab[1]  = '{clcd_pkg::CMD_LIGHT,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 3'd2,
                        {clcd_pkg::PREFIX_RST, clcd_pkg::LIGHT_ON_RST, 16'h0}};
        dir_tab[2]  = '{clcd_pkg::CMD_LIGHT,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd2,
                        {clcd_pkg::PREFIX_RST, clcd_pkg::LIGHT_OFF_RST, 16'h0}};
        dir_tab[3]  = '{clcd_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd4,
                        {clcd_pkg::PREFIX_RST, clcd_pkg::POSITION_RST, 8'h01, 8'h01}};
        // cursor requests outside the display are dropped
        dir_tab[4]  = '{clcd_pkg::CMD_SETCUR, 8'h00, 8'h02, 8'h00, 1'b0, 1'b1, 3'd0,
                        32'h0};
        dir_tab[5]  = '{clcd_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'h10, 1'b0, 1'b1, 3'd0,
                        32'h0};
        dir_tab[6]  = '{clcd_pkg::CMD_SETCUR, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1, 3'd0,
                        32'h0};
        dir_tab[7]  = '{clcd_pkg::CMD_SETCUR, 8'h00, 8'h01, 8'h0F, 1'b0, 1'b1, 3'd4,
                        {clcd_pkg::PREFIX_RST, clcd_pkg::POSITION_RST, 8'h10, 8'h02}};
        // last cell of last row: wraps back to the top
        dir_tab[8]  = '{clcd_pkg::CMD_PUTC,   8'h41, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0,
                        32'h0};
        // backspace at column 0 sends nothing
        dir_tab[9]  = '{clcd_pkg::CMD_PUTC,   clcd_pkg::CH_BS, 8'h00, 8'h00, 1'b0, 1'b1,
                        3'd0, 32'h0};
        dir_tab[10] = '{clcd_pkg::CMD_PUTC,   clcd_pkg::CH_PR_LO, 8'h00, 8'h00, 1'b0,
                        1'b0, 3'd0, 32'h0};
        dir_tab[11] = '{clcd_pkg::CMD_PUTC,   clcd_pkg::CH_PR_HI, 8'h00, 8'h00, 1'b0,
                        1'b0, 3'd0, 32'h0};
        // non-printable, non-control codes are ignored
        dir_tab[12] = '{clcd_pkg::CMD_PUTC,   8'h7F, 8'h00, 8'h00, 1'b0, 1'b1, 3'd0,
                        32'h0};
        dir_tab[13] = '{clcd_pkg::CMD_PUTC,   8'h1F, 8'h00, 8'h00, 1'b0, 1'b1, 3'd0,
                        32'h0};
        dir_tab[14] = '{clcd_pkg::CMD_PUTC,   8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 3'd0,
                        32'h0};
        dir_tab[15] = '{clcd_pkg::CMD_PUTC,   8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd0,
                        32'h0};
        dir_tab[16] = '{clcd_pkg::CMD_PUTC,   clcd_pkg::CH_BS, 8'h00, 8'h00, 1'b0, 1'b0,
                        3'd0, 32'h0};
        dir_tab[17] = '{clcd_pkg::CMD_PUTC,   clcd_pkg::CH_CR, 8'h00, 8'h00, 1'b0, 1'b0,
                        3'd0, 32'h0};
        dir_tab[18] = '{clcd_pkg::CMD_PUTC,   clcd_pkg::CH_LF, 8'h00, 8'h00, 1'b0, 1'b0,
                        3'd0, 32'h0};
        // second newline wraps the row back to 0
        dir_tab[19] = '{clcd_pkg::CMD_PUTC,   clcd_pkg::CH_LF, 8'h00, 8'h00, 1'b0, 1'b0,
                        3'd0, 32'h0};
        dir_tab[20] = '{clcd_pkg::CMD_SETCUR, 8'h00, 8'h00, 8'h0F, 1'b0, 1'b1, 3'd4,
                        {clcd_pkg::PREFIX_RST, clcd_pkg::POSITION_RST, 8'h10, 8'h01}};
        dir_tab[21] = '{clcd_pkg::CMD_PUTC,   8'h55, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0,
                        32'h0};
        dir_tab[22] = '{clcd_pkg::CMD_CLEAR,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 3'd2,
                        {clcd_pkg::PREFIX_RST, clcd_pkg::CLEAR_RST, 16'h0}};
        dir_tab[23] = '{clcd_pkg::CMD_LIGHT,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 3'd2,
                        {clcd_pkg::PREFIX_RST, clcd_pkg::LIGHT_ON_RST, 16'h0}};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, reset codes in force
        for (int i = 0; i < DIR_ROWS; i++) begin
            r = '{dir_tab[i].cmd, dir_tab[i].ch, dir_tab[i].trow, dir_tab[i].tcol,
                  dir_tab[i].light};
            send_request(r);
            work_out_bytes(r);
            if (dir_tab[i].typed) begin
                seq_buf.delete();
                for (k = 0; k < dir_tab[i].n_exp; k++)
                    seq_buf.push_back(dir_tab[i].exp_bytes[31 - 8 * k -: 8]);
            end
            queue_expected();
        end

        // Random phases: all-zero codes, all-ones codes, then random codes
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_and_settle();
            write_code(clcd_pkg::REG_PREFIX,    code_for_phase(ph));
            write_code(clcd_pkg::REG_POSITION,  code_for_phase(ph));
            write_code(clcd_pkg::REG_CLEAR,     code_for_phase(ph));
            write_code(clcd_pkg::REG_LIGHT_ON,  code_for_phase(ph));
            write_code(clcd_pkg::REG_LIGHT_OFF, code_for_phase(ph));
            i_cfg_we <= 1'b0;
            case (ph / 2)
                0: begin
                    send_idle_pct = 21;
                    stall_pct     = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    stall_pct     = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            repeat (PHASE_BEATS) begin
                r = pick_request();
                send_request(r);
                work_out_bytes(r);
                queue_expected();
            end
        end

        drain_and_settle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
